// ===== rtl/rtpm_pkg.sv =====
// ----------------------------------------------------------------------------
// rtpm_pkg - route table path matcher shared definitions
// Types, codes and defaults used by the matcher front, back and top level.
// ----------------------------------------------------------------------------
package rtpm_pkg;

  localparam int MAX_ROUTES_DEF    = 32;
  localparam int PATTERN_BYTES_DEF = 96;
  localparam int CMD_DEPTH         = 4;
  localparam int RES_DEPTH         = 2;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  typedef enum logic [1:0] {
    OP_PAT_BYTE,
    OP_PAT_END,
    OP_PATH_BYTE,
    OP_PATH_END
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SKIP_RD,
    S_SKIP_WR,
    S_M_RD,
    S_M_PAT,
    S_M_CMP,
    S_M_CMP2,
    S_E_RD,
    S_E_PAT,
    S_E_CHK,
    S_RESULT
  } state_t;

  typedef struct packed {
    op_t         op;
    logic [1:0]  method;
    logic [7:0]  ch;
    logic [15:0] handler;
    logic        auth;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] handler;
    logic        auth;
    logic [5:0]  count;
  } res_t;

endpackage

// ===== rtl/rtpm_ram.sv =====
// ----------------------------------------------------------------------------
// rtpm_ram - generic single write, single read RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rtpm_ram #(
  parameter int W = 8,
  parameter int D = 2,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem_r [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== rtl/rtpm_fifo.sv =====
// ----------------------------------------------------------------------------
// rtpm_fifo - small register queue
// Flip-flop FIFO used for the command queue and the result queue.
// ----------------------------------------------------------------------------
module rtpm_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] rdata_o,
  output logic         empty_o
);

  localparam int PTW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CTW = $clog2(DEPTH + 1);

  logic [W-1:0]   mem_r [DEPTH];
  logic [PTW-1:0] wp_r, rp_r;
  logic [CTW-1:0] cnt_r;
  logic           do_push, do_pop;

  assign full_o  = (cnt_r == CTW'(DEPTH));
  assign empty_o = (cnt_r == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PTW'(DEPTH - 1)) ? '0 : wp_r + PTW'(1);
      end
      if (do_pop) begin
        rp_r <= (rp_r == PTW'(DEPTH - 1)) ? '0 : rp_r + PTW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + CTW'(1);
        2'b01:   cnt_r <= cnt_r - CTW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== rtl/rtpm_front.sv =====
// ----------------------------------------------------------------------------
// rtpm_front - input classifier and command queue
// Sorts each item into pattern byte, pattern end, path byte or path end.
// ----------------------------------------------------------------------------
module rtpm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic              in_kind,
  input  logic [1:0]        in_method,
  input  logic [7:0]        in_char_byte,
  input  logic [15:0]       in_handler_id,
  input  logic              in_auth_flag,
  output rtpm_pkg::cmd_t    cmd_o,
  output logic              cmd_empty_o,
  input  logic              cmd_pop_i
);

  rtpm_pkg::cmd_t cmd_in;
  logic           is_end;

  assign is_end = (in_char_byte == rtpm_pkg::CH_NUL);

  always_comb begin
    cmd_in.method  = in_method;
    cmd_in.ch      = in_char_byte;
    cmd_in.handler = in_handler_id;
    cmd_in.auth    = in_auth_flag;
    unique case ({in_kind, is_end})
      2'b00:   cmd_in.op = rtpm_pkg::OP_PAT_BYTE;
      2'b01:   cmd_in.op = rtpm_pkg::OP_PAT_END;
      2'b10:   cmd_in.op = rtpm_pkg::OP_PATH_BYTE;
      default: cmd_in.op = rtpm_pkg::OP_PATH_END;
    endcase
  end

  rtpm_fifo #(
    .W     ($bits(rtpm_pkg::cmd_t)),
    .DEPTH (rtpm_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .wdata_i (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop_i),
    .rdata_o (cmd_o),
    .empty_o (cmd_empty_o)
  );

endmodule

// ===== rtl/rtpm_back.sv =====
// ----------------------------------------------------------------------------
// rtpm_back - route table sequencer
// Stores patterns, builds segment skips, steps route matchers, picks winner.
// ----------------------------------------------------------------------------
module rtpm_back #(
  parameter int MAX_ROUTES    = rtpm_pkg::MAX_ROUTES_DEF,
  parameter int PATTERN_BYTES = rtpm_pkg::PATTERN_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  rtpm_pkg::cmd_t cmd_i,
  input  logic           cmd_empty_i,
  output logic           cmd_pop_o,
  output rtpm_pkg::res_t res_o,
  output logic           res_push_o,
  input  logic           res_full_i
);

  localparam int RW    = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
  localparam int CW    = $clog2(MAX_ROUTES + 1);
  localparam int PW    = $clog2(PATTERN_BYTES);
  localparam int DEPTH = MAX_ROUTES * PATTERN_BYTES;
  localparam int AW    = $clog2(DEPTH);
  localparam int MW    = PW + 2;
  localparam int TW    = 19;

  rtpm_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]         total_r, total_nxt;
  logic [PW-1:0]         lpos_r, lpos_nxt;
  logic [RW-1:0]         idx_r, idx_nxt;
  logic [PW-1:0]         i_r, i_nxt;
  logic [PW-1:0]         next_r, next_nxt;
  logic [PW-1:0]         pos_r, pos_nxt;
  logic [PW-1:0]         ppos_r, ppos_nxt;
  logic                  wild_r, wild_nxt;
  logic                  mis_r, mis_nxt;
  logic                  mok_r, mok_nxt;
  logic [1:0]            rs_status_r, rs_status_nxt;
  logic [15:0]           rs_hand_r, rs_hand_nxt;
  logic                  rs_auth_r, rs_auth_nxt;
  logic [MAX_ROUTES-1:0] mvalid_r, mvalid_nxt;
  logic                  mv_r;

  // memory ports
  logic          pat_we;
  logic [AW-1:0] pat_waddr, pat_raddr;
  logic [7:0]    pat_wdata, pat_rdata;
  logic          skp_we;
  logic [AW-1:0] skp_waddr, skp_raddr;
  logic [PW-1:0] skp_wdata, skp_rdata;
  logic          ms_we;
  logic [MW-1:0] ms_wdata, ms_rdata, ms_eff;
  logic          rt_we;
  logic [TW-1:0] rt_wdata, rt_rdata;

  // shared decode
  logic          room, last, is_slash, ms_skip, colon, bad, p_room, hit;
  logic [AW-1:0] load_base, cur_base;
  logic [PW-1:0] eff_pos, skp, cmpp;
  logic [PW:0]   pinc;
  logic [MW-1:0] cmp_wr;
  logic [PW-1:0] sweep_nx;

  assign room      = (total_r < CW'(MAX_ROUTES));
  assign last      = (CW'(idx_r) == total_r - CW'(1));
  assign is_slash  = (cmd_i.ch == rtpm_pkg::CH_SLASH);
  assign load_base = AW'(total_r) * AW'(PATTERN_BYTES);
  assign cur_base  = AW'(idx_r) * AW'(PATTERN_BYTES);
  assign ms_eff    = mv_r ? ms_rdata : '0;
  assign eff_pos   = ms_eff[MW-1:2];
  assign ms_skip   = ms_eff[0] || (ms_eff[1] && !is_slash);
  assign colon     = !wild_r && (pat_rdata == rtpm_pkg::CH_COLON);
  assign skp       = (skp_rdata > PW'(PATTERN_BYTES - 1)) ? PW'(PATTERN_BYTES - 1) : skp_rdata;
  assign cmpp      = (state_r == rtpm_pkg::S_M_CMP2) ? ppos_r : pos_r;
  assign bad       = (pat_rdata == rtpm_pkg::CH_NUL) || (pat_rdata != cmd_i.ch);
  assign pinc      = {1'b0, cmpp} + (PW+1)'(1);
  assign p_room    = (pinc < (PW+1)'(PATTERN_BYTES));
  assign cmp_wr    = (bad || !p_room) ? {cmpp, 1'b0, 1'b1} : {pinc[PW-1:0], 1'b0, 1'b0};
  assign hit       = !mis_r && mok_r && (pat_rdata == rtpm_pkg::CH_NUL);
  assign sweep_nx  = (pat_rdata == rtpm_pkg::CH_SLASH) ? i_r : next_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rtpm_pkg::S_IDLE: begin
        if (!cmd_empty_i) begin
          unique case (cmd_i.op)
            rtpm_pkg::OP_PAT_BYTE:  state_nxt = rtpm_pkg::S_IDLE;
            rtpm_pkg::OP_PAT_END:   state_nxt = room ? rtpm_pkg::S_SKIP_RD : rtpm_pkg::S_RESULT;
            rtpm_pkg::OP_PATH_BYTE: state_nxt = (total_r != '0) ? rtpm_pkg::S_M_RD
                                                                : rtpm_pkg::S_IDLE;
            rtpm_pkg::OP_PATH_END:  state_nxt = (total_r != '0) ? rtpm_pkg::S_E_RD
                                                                : rtpm_pkg::S_RESULT;
          endcase
        end
      end
      rtpm_pkg::S_SKIP_RD: state_nxt = rtpm_pkg::S_SKIP_WR;
      rtpm_pkg::S_SKIP_WR: state_nxt = (i_r == '0) ? rtpm_pkg::S_RESULT : rtpm_pkg::S_SKIP_RD;
      rtpm_pkg::S_M_RD:    state_nxt = rtpm_pkg::S_M_PAT;
      rtpm_pkg::S_M_PAT: begin
        if (ms_skip) begin
          state_nxt = last ? rtpm_pkg::S_IDLE : rtpm_pkg::S_M_RD;
        end else begin
          state_nxt = rtpm_pkg::S_M_CMP;
        end
      end
      rtpm_pkg::S_M_CMP: begin
        if (colon && is_slash) begin
          state_nxt = rtpm_pkg::S_M_CMP2;
        end else begin
          state_nxt = last ? rtpm_pkg::S_IDLE : rtpm_pkg::S_M_RD;
        end
      end
      rtpm_pkg::S_M_CMP2:  state_nxt = last ? rtpm_pkg::S_IDLE : rtpm_pkg::S_M_RD;
      rtpm_pkg::S_E_RD:    state_nxt = rtpm_pkg::S_E_PAT;
      rtpm_pkg::S_E_PAT:   state_nxt = rtpm_pkg::S_E_CHK;
      rtpm_pkg::S_E_CHK:   state_nxt = (hit || last) ? rtpm_pkg::S_RESULT : rtpm_pkg::S_E_RD;
      rtpm_pkg::S_RESULT:  state_nxt = res_full_i ? rtpm_pkg::S_RESULT : rtpm_pkg::S_IDLE;
      default:             state_nxt = rtpm_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    total_nxt     = total_r;
    lpos_nxt      = lpos_r;
    idx_nxt       = idx_r;
    i_nxt         = i_r;
    next_nxt      = next_r;
    pos_nxt       = pos_r;
    ppos_nxt      = ppos_r;
    wild_nxt      = wild_r;
    mis_nxt       = mis_r;
    mok_nxt       = mok_r;
    rs_status_nxt = rs_status_r;
    rs_hand_nxt   = rs_hand_r;
    rs_auth_nxt   = rs_auth_r;
    mvalid_nxt    = mvalid_r;
    cmd_pop_o     = 1'b0;
    res_push_o    = 1'b0;
    pat_we        = 1'b0;
    pat_waddr     = load_base + AW'(lpos_r);
    pat_wdata     = cmd_i.ch;
    pat_raddr     = cur_base;
    skp_we        = 1'b0;
    skp_waddr     = load_base + AW'(i_r);
    skp_wdata     = sweep_nx;
    skp_raddr     = cur_base + AW'(eff_pos);
    ms_we         = 1'b0;
    ms_wdata      = cmp_wr;
    rt_we         = 1'b0;
    rt_wdata      = {cmd_i.method, cmd_i.handler, cmd_i.auth};

    unique case (state_r)
      rtpm_pkg::S_IDLE: begin
        if (!cmd_empty_i) begin
          unique case (cmd_i.op)
            rtpm_pkg::OP_PAT_BYTE: begin
              cmd_pop_o = 1'b1;
              if (room && (lpos_r < PW'(PATTERN_BYTES - 1))) begin
                pat_we   = 1'b1;
                lpos_nxt = lpos_r + PW'(1);
              end
            end
            rtpm_pkg::OP_PAT_END: begin
              rs_hand_nxt = '0;
              rs_auth_nxt = 1'b0;
              if (room) begin
                pat_we    = 1'b1;
                pat_wdata = rtpm_pkg::CH_NUL;
                rt_we     = 1'b1;
                i_nxt     = lpos_r;
                next_nxt  = lpos_r;
              end else begin
                rs_status_nxt = rtpm_pkg::ST_FULL;
                lpos_nxt      = '0;
              end
            end
            rtpm_pkg::OP_PATH_BYTE: begin
              idx_nxt = '0;
              if (total_r == '0) begin
                cmd_pop_o = 1'b1;
              end
            end
            rtpm_pkg::OP_PATH_END: begin
              idx_nxt       = '0;
              rs_status_nxt = rtpm_pkg::ST_MISS;
              rs_hand_nxt   = '0;
              rs_auth_nxt   = 1'b0;
            end
          endcase
        end
      end
      rtpm_pkg::S_SKIP_RD: begin
        pat_raddr = load_base + AW'(i_r);
      end
      rtpm_pkg::S_SKIP_WR: begin
        skp_we   = 1'b1;
        next_nxt = sweep_nx;
        if (i_r == '0) begin
          total_nxt     = total_r + CW'(1);
          lpos_nxt      = '0;
          rs_status_nxt = rtpm_pkg::ST_OK;
        end else begin
          i_nxt = i_r - PW'(1);
        end
      end
      rtpm_pkg::S_M_RD: begin
      end
      rtpm_pkg::S_M_PAT: begin
        pat_raddr = cur_base + AW'(eff_pos);
        pos_nxt   = eff_pos;
        wild_nxt  = ms_eff[1];
        if (ms_skip) begin
          if (last) begin
            cmd_pop_o = 1'b1;
          end else begin
            idx_nxt = idx_r + RW'(1);
          end
        end
      end
      rtpm_pkg::S_M_CMP: begin
        pat_raddr = cur_base + AW'(skp);
        ppos_nxt  = skp;
        if (!(colon && is_slash)) begin
          ms_we             = 1'b1;
          mvalid_nxt[idx_r] = 1'b1;
          if (colon) begin
            ms_wdata = {skp, 1'b1, 1'b0};
          end
          if (last) begin
            cmd_pop_o = 1'b1;
          end else begin
            idx_nxt = idx_r + RW'(1);
          end
        end
      end
      rtpm_pkg::S_M_CMP2: begin
        ms_we             = 1'b1;
        mvalid_nxt[idx_r] = 1'b1;
        if (last) begin
          cmd_pop_o = 1'b1;
        end else begin
          idx_nxt = idx_r + RW'(1);
        end
      end
      rtpm_pkg::S_E_RD: begin
      end
      rtpm_pkg::S_E_PAT: begin
        pat_raddr   = cur_base + AW'(eff_pos);
        mis_nxt     = ms_eff[0];
        mok_nxt     = (rt_rdata[TW-1:TW-2] == cmd_i.method);
        rs_hand_nxt = rt_rdata[16:1];
        rs_auth_nxt = rt_rdata[0];
      end
      rtpm_pkg::S_E_CHK: begin
        if (hit) begin
          rs_status_nxt = rtpm_pkg::ST_OK;
        end else begin
          rs_hand_nxt = '0;
          rs_auth_nxt = 1'b0;
          if (!last) begin
            idx_nxt = idx_r + RW'(1);
          end
        end
      end
      rtpm_pkg::S_RESULT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          cmd_pop_o  = 1'b1;
          if (cmd_i.op == rtpm_pkg::OP_PATH_END) begin
            mvalid_nxt = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign res_o.status  = rs_status_r;
  assign res_o.handler = rs_hand_r;
  assign res_o.auth    = rs_auth_r;
  assign res_o.count   = 6'(total_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= rtpm_pkg::S_IDLE;
      total_r  <= '0;
      lpos_r   <= '0;
      mvalid_r <= '0;
    end else begin
      state_r  <= state_nxt;
      total_r  <= total_nxt;
      lpos_r   <= lpos_nxt;
      mvalid_r <= mvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    i_r         <= i_nxt;
    next_r      <= next_nxt;
    pos_r       <= pos_nxt;
    ppos_r      <= ppos_nxt;
    wild_r      <= wild_nxt;
    mis_r       <= mis_nxt;
    mok_r       <= mok_nxt;
    rs_status_r <= rs_status_nxt;
    rs_hand_r   <= rs_hand_nxt;
    rs_auth_r   <= rs_auth_nxt;
    mv_r        <= mvalid_r[idx_r];
  end

  rtpm_ram #(.W(8), .D(DEPTH)) u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (pat_waddr),
    .wdata (pat_wdata),
    .raddr (pat_raddr),
    .rdata (pat_rdata)
  );

  rtpm_ram #(.W(PW), .D(DEPTH)) u_skip_ram (
    .clk   (clk),
    .we    (skp_we),
    .waddr (skp_waddr),
    .wdata (skp_wdata),
    .raddr (skp_raddr),
    .rdata (skp_rdata)
  );

  rtpm_ram #(.W(MW), .D(MAX_ROUTES)) u_match_ram (
    .clk   (clk),
    .we    (ms_we),
    .waddr (idx_r),
    .wdata (ms_wdata),
    .raddr (idx_r),
    .rdata (ms_rdata)
  );

  rtpm_ram #(.W(TW), .D(MAX_ROUTES)) u_route_ram (
    .clk   (clk),
    .we    (rt_we),
    .waddr (RW'(total_r)),
    .wdata (rt_wdata),
    .raddr (idx_r),
    .rdata (rt_rdata)
  );

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push_o |-> !res_full_i)
    else $error("result pushed into full queue");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop_o |-> !cmd_empty_i)
    else $error("command popped from empty queue");

  a_busy_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != rtpm_pkg::S_IDLE) |-> !cmd_empty_i)
    else $error("sequencer busy without a command at head");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push_o && cmd_i.op == rtpm_pkg::OP_PATH_END) |=> (mvalid_r == '0))
    else $error("matchers not cleared after path end");

  a_lpos: assert property (@(posedge clk) disable iff (!rst_n)
    lpos_r <= PW'(PATTERN_BYTES - 1))
    else $error("load position out of range");

endmodule

// ===== rtl/route_table_path_matcher.sv =====
// ----------------------------------------------------------------------------
// route_table_path_matcher - URL route table with wildcard segments
// Registers route patterns and matches request paths against them.
// ----------------------------------------------------------------------------
// Items arrive one string byte at a time through a queue-style port (push /
// full) and land in a short command queue, so the sender is held off only
// when that queue fills. A pattern terminator stores the route and then
// sweeps the pattern backward once to build the segment skip table. A path
// byte visits each registered route in turn: a route that has already failed
// or sits inside a ':' segment while the byte is not '/' is passed over once
// its state is read; any other route compares the byte with its pattern,
// with an extra compare step when a ':' segment is entered on a '/'. A path
// terminator checks routes in turn up to the first hit. The pattern memory
// has a single read port, which every route matcher visits in turn. Results
// wait in a two-entry result queue (empty / pop), so the sequencer keeps
// going while the consumer stalls, until that queue fills. Route count is
// the number of routes after the item.
// ----------------------------------------------------------------------------
module route_table_path_matcher #(
  parameter int MAX_ROUTES    = rtpm_pkg::MAX_ROUTES_DEF,
  parameter int PATTERN_BYTES = rtpm_pkg::PATTERN_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input item channel
  input  logic        push,
  output logic        full,
  input  logic        in_kind,
  input  logic [1:0]  in_method,
  input  logic [7:0]  in_char_byte,
  input  logic [15:0] in_handler_id,
  input  logic        in_auth_flag,
  // result item channel
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_status,
  output logic [15:0] out_handler_out,
  output logic        out_auth_out,
  output logic [5:0]  out_route_count
);

  rtpm_pkg::cmd_t cmd;
  logic           cmd_empty, cmd_pop;
  rtpm_pkg::res_t res_in, res_out;
  logic           res_push, res_full;

  // front: classify and queue
  rtpm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_kind       (in_kind),
    .in_method     (in_method),
    .in_char_byte  (in_char_byte),
    .in_handler_id (in_handler_id),
    .in_auth_flag  (in_auth_flag),
    .cmd_o         (cmd),
    .cmd_empty_o   (cmd_empty),
    .cmd_pop_i     (cmd_pop)
  );

  // back: table storage, skip build, matcher stepping
  rtpm_back #(
    .MAX_ROUTES    (MAX_ROUTES),
    .PATTERN_BYTES (PATTERN_BYTES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_i       (cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res_in),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  // result queue decouples the consumer
  rtpm_fifo #(
    .W     ($bits(rtpm_pkg::res_t)),
    .DEPTH (rtpm_pkg::RES_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign out_status      = res_out.status;
  assign out_handler_out = res_out.handler;
  assign out_auth_out    = res_out.auth;
  assign out_route_count = res_out.count;

endmodule
